// ===== rtl/core/tarm_pkg.sv =====
package tarm_pkg;

  // fixed field widths of the instruction and result
  localparam int MODE_W  = 4;
  localparam int PC_W    = 10;
  localparam int IMM_W   = 32;
  localparam int PRINT_W = 32;

  // multiplier digit width (bits of the second operand per step)
  localparam int MUL_DIGIT_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_HALT  = 4'd0,
    MODE_ADD   = 4'd1,
    MODE_MUL   = 4'd2,
    MODE_SUB   = 4'd3,
    MODE_DIV   = 4'd4,
    MODE_COPY  = 4'd5,
    MODE_IMM   = 4'd6,
    MODE_JUMP  = 4'd7,
    MODE_JZ    = 4'd8,
    MODE_LT    = 4'd9,
    MODE_GT    = 4'd10,
    MODE_EQ    = 4'd11,
    MODE_PRINT = 4'd12,
    MODE_SAVE  = 4'd13
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic read;
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mul_op;
    logic div_op;
    logic mul_last;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/core/tarm_ctrl.sv =====
module tarm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tarm_pkg::dp_status_t  status_i,
  output tarm_pkg::dp_cmd_t     cmd_o,
  output logic                  busy_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        priority if (status_i.mul_op) begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end else if (status_i.div_op) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/core/tarm_datapath.sv =====
module tarm_datapath #(
  parameter int NUM_REGS   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tarm_pkg::dp_cmd_t                   cmd_i,
  output tarm_pkg::dp_status_t                status_o,
  input  logic [tarm_pkg::MODE_W-1:0]         mode_i,
  input  logic [tarm_pkg::PC_W-1:0]           dest_or_target_i,
  input  logic signed [tarm_pkg::IMM_W-1:0]   operand_a_i,
  input  logic [tarm_pkg::PC_W-1:0]           operand_b_i,
  output logic [tarm_pkg::PC_W-1:0]           next_pc_o,
  output logic                                print_valid_o,
  output logic signed [tarm_pkg::PRINT_W-1:0] print_value_o,
  output logic                                halted_o,
  output logic                                div_error_o,
  output logic                                done_o
);

  localparam int PC_W      = tarm_pkg::PC_W;
  localparam int MEM_DEPTH = (NUM_REGS < (1 << PC_W)) ? NUM_REGS : (1 << PC_W);
  localparam int IDX_W     = $clog2(MEM_DEPTH);
  localparam int RCP_SH    = 2 * PC_W;
  localparam int RCP       = ((1 << RCP_SH) + MEM_DEPTH - 1) / MEM_DEPTH;
  localparam int PROD_W    = PC_W + RCP_SH + 1;
  localparam int MUL_DIG   = tarm_pkg::MUL_DIGIT_W;
  localparam int MUL_STEPS = (DATA_WIDTH + MUL_DIG - 1) / MUL_DIG;
  localparam int BX_W      = MUL_STEPS * MUL_DIG;
  localparam int STEP_W    = $clog2(DATA_WIDTH);

  // register index modulo the file depth, by reciprocal multiply and one correction
  function automatic logic [IDX_W-1:0] reg_idx(input logic [PC_W-1:0] v);
    logic [PROD_W-1:0] prod;
    logic [PC_W-1:0]   q;
    logic [2*PC_W:0]   qm;
    logic [PC_W:0]     r;
    prod = PROD_W'(v) * PROD_W'(RCP);
    q    = prod[RCP_SH +: PC_W];
    qm   = (2*PC_W+1)'(q) * (2*PC_W+1)'(MEM_DEPTH);
    r    = {1'b0, v} - qm[PC_W:0];
    if (r >= (PC_W+1)'(MEM_DEPTH)) begin
      r = r - (PC_W+1)'(MEM_DEPTH);
    end
    return r[IDX_W-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem_q [MEM_DEPTH];

  // latched instruction
  logic [tarm_pkg::MODE_W-1:0]       mode_q;
  logic [PC_W-1:0]                   dest_q;
  logic [IDX_W-1:0]                  d_idx_q, a_idx_q, b_idx_q;
  logic signed [tarm_pkg::IMM_W-1:0] imm_q;

  logic [PC_W-1:0]       pc_q;
  logic                  halt_q;
  logic                  done_q;
  logic [IDX_W-1:0]      clr_q;
  logic [STEP_W-1:0]     step_q;
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [IDX_W-1:0]      addr_a;

  // multiply and divide state
  logic [DATA_WIDTH-1:0] mul_a_q, acc_q;
  logic [BX_W-1:0]       mul_b_q;
  logic [DATA_WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic                  neg_q;
  logic [DATA_WIDTH-1:0] mag_a, mag_b, rem_d, quo_signed;
  logic [DATA_WIDTH:0]   shifted, trial;
  logic                  ge;

  logic [DATA_WIDTH-1:0] res;
  logic                  wr_en;
  logic [PC_W-1:0]       nxt_pc;
  logic                  div_zero;

  // jump-if-zero and print read the named register on port a
  assign addr_a = ((mode_q == tarm_pkg::MODE_JZ) || (mode_q == tarm_pkg::MODE_PRINT))
                  ? d_idx_q : a_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.commit && wr_en) begin
      mem_q[d_idx_q] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_a_q <= mem_q[addr_a];
      rd_b_q <= mem_q[b_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      dest_q  <= dest_or_target_i;
      imm_q   <= operand_a_i;
      d_idx_q <= reg_idx(dest_or_target_i);
      a_idx_q <= reg_idx(operand_a_i[PC_W-1:0]);
      b_idx_q <= reg_idx(operand_b_i);
    end
  end

  // divider step: restoring, one quotient bit per cycle
  assign mag_a      = rd_a_q[DATA_WIDTH-1] ? ('0 - rd_a_q) : rd_a_q;
  assign mag_b      = rd_b_q[DATA_WIDTH-1] ? ('0 - rd_b_q) : rd_b_q;
  assign shifted    = {rem_q, quo_q[DATA_WIDTH-1]};
  assign trial      = shifted - {1'b0, dvs_q};
  assign ge         = (shifted >= {1'b0, dvs_q});
  assign rem_d      = ge ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  assign quo_signed = neg_q ? ('0 - quo_q) : quo_q;
  assign div_zero   = (rd_b_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_a_q <= rd_a_q;
      mul_b_q <= BX_W'(rd_b_q);
      acc_q   <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q   <= acc_q + DATA_WIDTH'(mul_a_q * mul_b_q[MUL_DIG-1:0]);
      mul_a_q <= mul_a_q << MUL_DIG;
      mul_b_q <= mul_b_q >> MUL_DIG;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= rd_a_q[DATA_WIDTH-1] ^ rd_b_q[DATA_WIDTH-1];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
    end
  end

  always_comb begin
    res    = '0;
    wr_en  = 1'b0;
    nxt_pc = pc_q + 1'b1;
    case (mode_q)
      tarm_pkg::MODE_HALT: nxt_pc = pc_q;
      tarm_pkg::MODE_ADD: begin
        res   = rd_a_q + rd_b_q;
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_MUL: begin
        res   = acc_q;
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_SUB: begin
        res   = rd_a_q - rd_b_q;
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_DIV: begin
        res   = div_zero ? '0 : quo_signed;
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_COPY: begin
        res   = rd_a_q;
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_IMM: begin
        res   = DATA_WIDTH'(imm_q);
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_JUMP: nxt_pc = dest_q;
      tarm_pkg::MODE_JZ: begin
        if (rd_a_q == '0) begin
          nxt_pc = imm_q[PC_W-1:0];
        end
      end
      tarm_pkg::MODE_LT: begin
        res   = DATA_WIDTH'($signed(rd_a_q) < $signed(rd_b_q));
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_GT: begin
        res   = DATA_WIDTH'($signed(rd_b_q) < $signed(rd_a_q));
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_EQ: begin
        res   = DATA_WIDTH'(rd_a_q == rd_b_q);
        wr_en = 1'b1;
      end
      tarm_pkg::MODE_SAVE: begin
        res   = DATA_WIDTH'(pc_q);
        wr_en = 1'b1;
      end
      default: ;
    endcase
    if (halt_q) begin
      wr_en  = 1'b0;
      nxt_pc = pc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
      done_q <= 1'b0;
      clr_q  <= '0;
      step_q <= '0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.mul_start || cmd_i.div_start) begin
        step_q <= '0;
      end else if (cmd_i.mul_step || cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.commit) begin
        pc_q <= nxt_pc;
        if (mode_q == tarm_pkg::MODE_HALT) begin
          halt_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      next_pc_o     <= nxt_pc;
      print_valid_o <= !halt_q && (mode_q == tarm_pkg::MODE_PRINT);
      print_value_o <= (!halt_q && (mode_q == tarm_pkg::MODE_PRINT))
                       ? tarm_pkg::PRINT_W'($signed(rd_a_q)) : '0;
      halted_o      <= halt_q || (mode_q == tarm_pkg::MODE_HALT);
      div_error_o   <= !halt_q && (mode_q == tarm_pkg::MODE_DIV) && div_zero;
    end
  end

  assign done_o = done_q;

  assign status_o.clr_last = (clr_q == IDX_W'(MEM_DEPTH - 1));
  assign status_o.mul_op   = !halt_q && (mode_q == tarm_pkg::MODE_MUL);
  assign status_o.div_op   = !halt_q && (mode_q == tarm_pkg::MODE_DIV) && !div_zero;
  assign status_o.mul_last = (step_q == STEP_W'(MUL_STEPS - 1));
  assign status_o.div_last = (step_q == STEP_W'(DATA_WIDTH - 1));

endmodule

// ===== rtl/core/three_address_register_machine_exec_top.sv =====
// result: strobed after the register file read, execute and write-back for most modes;
//   multiply works one 16-bit digit per cycle, then write-back,
//   divide by a nonzero register works one quotient bit per cycle, then write-back
// a new instruction is taken only after the previous one has been written back;
//   the receiver cannot stall, results are simply strobed out
// reset: busy while all min(NUM_REGS,1024) entries of the register file are swept to zero
module three_address_register_machine_exec_top #(
  parameter int NUM_REGS   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command side: a transaction is taken when start_i is high and busy_o is low
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [tarm_pkg::MODE_W-1:0]         mode_i,
  input  logic [tarm_pkg::PC_W-1:0]           dest_or_target_i,
  input  logic signed [tarm_pkg::IMM_W-1:0]   operand_a_i,
  input  logic [tarm_pkg::PC_W-1:0]           operand_b_i,
  // result side: one cycle strobe per transaction
  output logic                                done_o,
  output logic [tarm_pkg::PC_W-1:0]           next_pc_o,
  output logic                                print_valid_o,
  output logic signed [tarm_pkg::PRINT_W-1:0] print_value_o,
  output logic                                halted_o,
  output logic                                div_error_o
);

  // command and status between sequencer and datapath
  tarm_pkg::dp_cmd_t    cmd;
  tarm_pkg::dp_status_t status;

  // sequencer: clear sweep, read, execute, multi-cycle mul/div, write-back
  tarm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath: register file memory, program counter, halt flag,
  // digit-serial multiplier, bit-serial divider and result registers
  tarm_datapath #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (mode_i),
    .dest_or_target_i (dest_or_target_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .next_pc_o        (next_pc_o),
    .print_valid_o    (print_valid_o),
    .print_value_o    (print_value_o),
    .halted_o         (halted_o),
    .div_error_o      (div_error_o),
    .done_o           (done_o)
  );

endmodule

// ===== rtl/core/tarm_checker.sv =====
module tarm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic print_valid_o,
  input logic halted_o,
  input logic div_error_o
);

  // a result only comes out once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accepting a transaction");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && halted_o) |-> (!print_valid_o && !div_error_o))
    else $error("print or divide error while halted");

  a_print_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && print_valid_o) |-> !div_error_o)
    else $error("print and divide error in one result");

endmodule

bind three_address_register_machine_exec_top tarm_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .print_valid_o (print_valid_o),
  .halted_o      (halted_o),
  .div_error_o   (div_error_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // opcodes the block treats as no-ops, not part of the package enum
  localparam logic [tarm_pkg::MODE_W-1:0] MODE_NOP_14 = 4'd14;
  localparam logic [tarm_pkg::MODE_W-1:0] MODE_NOP_15 = 4'd15;

  localparam int NUM_REGS       = 1024;
  localparam int RANDOM_INSTRS  = 900;
  // instruction counts bounding the stretch with no idle gaps on the command side
  localparam int QUIET_FIRST    = 300;
  localparam int QUIET_LAST     = 500;
  // cycles to let pass after the last result, above the longest divide latency
  localparam int DRAIN_CYCLES   = 60;

  // one fetched instruction, as driven onto the command ports
  typedef struct packed {
    logic [tarm_pkg::MODE_W-1:0]  mode;
    logic [tarm_pkg::PC_W-1:0]    dest;
    logic [tarm_pkg::IMM_W-1:0]   opa;
    logic [tarm_pkg::PC_W-1:0]    opb;
  } instr_t;

  // one strobed result of the block
  typedef struct packed {
    logic [tarm_pkg::PC_W-1:0]    next_pc;
    logic                         print_valid;
    logic [tarm_pkg::PRINT_W-1:0] print_value;
    logic                         halted;
    logic                         div_error;
  } exec_result_t;

  logic                                clk_i            = 1'b0;
  logic                                rst_ni           = 1'b0;
  logic                                start_i          = 1'b0;
  logic [tarm_pkg::MODE_W-1:0]         mode_i           = '0;
  logic [tarm_pkg::PC_W-1:0]           dest_or_target_i = '0;
  logic signed [tarm_pkg::IMM_W-1:0]   operand_a_i      = '0;
  logic [tarm_pkg::PC_W-1:0]           operand_b_i      = '0;
  logic                                busy_o;
  logic                                done_o;
  logic [tarm_pkg::PC_W-1:0]           next_pc_o;
  logic                                print_valid_o;
  logic signed [tarm_pkg::PRINT_W-1:0] print_value_o;
  logic                                halted_o;
  logic                                div_error_o;

  three_address_register_machine_exec_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .dest_or_target_i (dest_or_target_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .done_o           (done_o),
    .next_pc_o        (next_pc_o),
    .print_valid_o    (print_valid_o),
    .print_value_o    (print_value_o),
    .halted_o         (halted_o),
    .div_error_o      (div_error_o)
  );

  // shadow machine state, advanced once per accepted transaction
  logic signed [31:0]          shadow_regs [NUM_REGS];
  logic [tarm_pkg::PC_W-1:0]   shadow_pc;
  logic                        shadow_halted;

  instr_t       pending_instrs [$];
  exec_result_t expected_results [$];
  instr_t       in_flight;
  int           idle_left       = 0;
  int           instr_issued    = 0;
  int           results_checked = 0;
  int           prints_seen     = 0;
  int           div_faults_seen = 0;
  int           error_count     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // register index: mostly the low sixteen so that values get reused,
  // now and then anywhere in the file
  function automatic logic [tarm_pkg::PC_W-1:0] pick_reg();
    if ($urandom_range(9) < 8) return tarm_pkg::PC_W'($urandom_range(15));
    return tarm_pkg::PC_W'($urandom_range(NUM_REGS - 1));
  endfunction

  function automatic instr_t make_instr(logic [tarm_pkg::MODE_W-1:0] mode,
                                        logic [tarm_pkg::PC_W-1:0] dest,
                                        logic [tarm_pkg::IMM_W-1:0] opa,
                                        logic [tarm_pkg::PC_W-1:0] opb);
    instr_t ins;
    ins.mode = mode;
    ins.dest = dest;
    ins.opa  = opa;
    ins.opb  = opb;
    return ins;
  endfunction

  // executes one instruction on the shadow machine and returns what the block
  // should strobe out for it
  function automatic exec_result_t execute_instruction(instr_t ins);
    exec_result_t              res;
    logic signed [31:0]        va;
    logic signed [31:0]        vb;
    logic [tarm_pkg::PC_W-1:0] nxt;
    longint                    quo;
    res = '0;
    va  = shadow_regs[ins.opa[tarm_pkg::PC_W-1:0]];
    vb  = shadow_regs[ins.opb];
    nxt = shadow_pc + 10'd1;  // wraps from 1023 to 0
    if (shadow_halted) begin
      nxt = shadow_pc;
    end else begin
      case (ins.mode)
        tarm_pkg::MODE_HALT: begin
          shadow_halted = 1'b1;
          nxt = shadow_pc;
        end
        tarm_pkg::MODE_ADD:  shadow_regs[ins.dest] = va + vb;
        tarm_pkg::MODE_MUL:  shadow_regs[ins.dest] = va * vb;
        tarm_pkg::MODE_SUB:  shadow_regs[ins.dest] = va - vb;
        tarm_pkg::MODE_DIV: begin
          if (vb == 0) begin
            shadow_regs[ins.dest] = '0;
            res.div_error = 1'b1;
          end else begin
            // 64-bit quotient so most negative over minus one wraps cleanly
            quo = longint'(va) / longint'(vb);
            shadow_regs[ins.dest] = quo[31:0];
          end
        end
        tarm_pkg::MODE_COPY: shadow_regs[ins.dest] = va;
        tarm_pkg::MODE_IMM:  shadow_regs[ins.dest] = ins.opa;
        tarm_pkg::MODE_JUMP: nxt = ins.dest;
        tarm_pkg::MODE_JZ: begin
          if (shadow_regs[ins.dest] == 0) nxt = ins.opa[tarm_pkg::PC_W-1:0];
        end
        tarm_pkg::MODE_LT:   shadow_regs[ins.dest] = (va < vb) ? 32'sd1 : 32'sd0;
        tarm_pkg::MODE_GT:   shadow_regs[ins.dest] = (va > vb) ? 32'sd1 : 32'sd0;
        tarm_pkg::MODE_EQ:   shadow_regs[ins.dest] = (va == vb) ? 32'sd1 : 32'sd0;
        tarm_pkg::MODE_PRINT: begin
          res.print_valid = 1'b1;
          res.print_value = shadow_regs[ins.dest];
        end
        tarm_pkg::MODE_SAVE: shadow_regs[ins.dest] = {22'd0, shadow_pc};
        default: ;  // the two spare opcodes only advance the counter
      endcase
      shadow_pc = nxt;
    end
    res.next_pc = nxt;
    res.halted  = shadow_halted;
    return res;
  endfunction

  // command side driver: a transaction is taken at an edge where start is high
  // and busy is low; start is held until then, and each signal gets a single
  // nonblocking update per edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.push_back(execute_instruction(in_flight));
        instr_issued++;
      end
      if (!start_i || !busy_o) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
        end else if (pending_instrs.size() > 0 &&
                     !(instr_issued >= QUIET_FIRST && instr_issued < QUIET_LAST) &&
                     $urandom_range(99) < 13) begin
          // gaps of varying length so they land on every phase of the work
          idle_left = $urandom_range(5);
          start_i <= 1'b0;
        end else if (pending_instrs.size() > 0) begin
          in_flight = pending_instrs.pop_front();
          mode_i           <= in_flight.mode;
          dest_or_target_i <= in_flight.dest;
          operand_a_i      <= in_flight.opa;
          operand_b_i      <= in_flight.opb;
          start_i          <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    $display("%0t: %s expected 0x%08h actual 0x%08h", $time, field, want, got);
  endtask

  // result monitor: each strobe is checked against the oldest expectation
  always @(posedge clk_i) begin
    exec_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no transaction outstanding, expected none actual next_pc %0d",
                 $time, next_pc_o);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (print_valid_o) prints_seen++;
        if (div_error_o) div_faults_seen++;
        if (next_pc_o !== want.next_pc)
          note_mismatch("next_pc", 32'(want.next_pc), 32'(next_pc_o));
        if (print_valid_o !== want.print_valid)
          note_mismatch("print_valid", 32'(want.print_valid), 32'(print_valid_o));
        if (print_value_o !== want.print_value)
          note_mismatch("print_value", want.print_value, print_value_o);
        if (halted_o !== want.halted)
          note_mismatch("halted", 32'(want.halted), 32'(halted_o));
        if (div_error_o !== want.div_error)
          note_mismatch("div_error", 32'(want.div_error), 32'(div_error_o));
      end
    end
  end

  // stimulus and end of run
  initial begin
    instr_t      ins;
    int          pick;
    logic [31:0] word;

    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_pc     = '0;
    shadow_halted = 1'b0;

    // directed: extremes, every opcode but halt, the corner cases of divide, jumps
    // and counter wrap
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_IMM,  10'd1,  32'h8000_0000, 10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_IMM,  10'd2,  32'hFFFF_FFFF, 10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_IMM,  10'd3,  32'h7FFF_FFFF, 10'd0));
    // most negative over minus one, then divide by an empty register
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_DIV,  10'd4,  32'd1,         10'd2));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_DIV,  10'd5,  32'd3,         10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_ADD,  10'd6,  32'd3,         10'd3));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_MUL,  10'd7,  32'd1,         10'd2));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_SUB,  10'd8,  32'd1,         10'd3));
    // upper bits of the source field must be ignored
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_COPY, 10'd9,  32'hFFFF_FC01, 10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_LT,   10'd10, 32'd1,         10'd3));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_GT,   10'd11, 32'd1,         10'd3));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_EQ,   10'd12, 32'd2,         10'd2));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_PRINT, 10'd4, 32'd0,         10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_SAVE, 10'd13, 32'd0,         10'd0));
    // jump to the top address, then a no-op wraps the counter to zero
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_JUMP, 10'd1023, 32'd0,       10'd0));
    pending_instrs.push_back(make_instr(MODE_NOP_14, 10'd0,  32'd0,         10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_JZ,   10'd0,  32'hFFFF_FFFF, 10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_JZ,   10'd2,  32'd77,        10'd0));
    pending_instrs.push_back(make_instr(MODE_NOP_15, 10'd1023, 32'hFFFF_FFFF, 10'd1023));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_IMM,  10'd1023, 32'h1234_5678, 10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_DIV,  10'd14, 32'd1,         10'd1023));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_PRINT, 10'd1023, 32'd0,      10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_PRINT, 10'd14, 32'd0,        10'd0));

    // random programs: no halt here, it would freeze everything after it
    repeat (RANDOM_INSTRS) begin
      word     = $urandom();
      ins.dest = pick_reg();
      ins.opb  = pick_reg();
      ins.opa  = {word[31:10], pick_reg()};
      pick     = $urandom_range(99);
      if (pick < 18) begin
        ins.mode = tarm_pkg::MODE_IMM;
        case ($urandom_range(7))
          0: ins.opa = '0;
          1: ins.opa = 32'd1;
          2: ins.opa = '1;
          3: ins.opa = 32'h8000_0000;
          4: ins.opa = 32'h7FFF_FFFF;
          5: ins.opa = 32'($urandom_range(16)) - 32'd8;
          default: ins.opa = word;
        endcase
      end
      else if (pick < 28) ins.mode = tarm_pkg::MODE_ADD;
      else if (pick < 36) ins.mode = tarm_pkg::MODE_MUL;
      else if (pick < 44) ins.mode = tarm_pkg::MODE_SUB;
      else if (pick < 54) ins.mode = tarm_pkg::MODE_DIV;
      else if (pick < 59) ins.mode = tarm_pkg::MODE_COPY;
      else if (pick < 64) ins.mode = tarm_pkg::MODE_LT;
      else if (pick < 69) ins.mode = tarm_pkg::MODE_GT;
      else if (pick < 74) ins.mode = tarm_pkg::MODE_EQ;
      else if (pick < 82) ins.mode = tarm_pkg::MODE_PRINT;
      else if (pick < 86) ins.mode = tarm_pkg::MODE_SAVE;
      else if (pick < 89) ins.mode = tarm_pkg::MODE_JUMP;
      else if (pick < 94) ins.mode = tarm_pkg::MODE_JZ;
      else if (pick < 97) ins.mode = MODE_NOP_14;
      else                ins.mode = MODE_NOP_15;
      pending_instrs.push_back(ins);
    end

    // halt last: everything after it must see a frozen machine
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_HALT,  10'd5, 32'd9,  10'd3));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_PRINT, 10'd1, 32'd0,  10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_DIV,   10'd5, 32'd1,  10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_JUMP,  10'd5, 32'd0,  10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_IMM,   10'd1, 32'd42, 10'd0));
    pending_instrs.push_back(make_instr(tarm_pkg::MODE_PRINT, 10'd1, 32'd0,  10'd0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // checked on the falling edge so all rising-edge updates have settled
    while (pending_instrs.size() > 0 || start_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d instructions executed across all opcodes, %0d results checked",
             instr_issued, results_checked);
    $display("%0d register prints and %0d divides by zero seen, run ended halted",
             prints_seen, div_faults_seen);
    if (error_count == 0) begin
      $display("three_address_register_machine_exec_top: match");
    end else begin
      $display("three_address_register_machine_exec_top: mismatch");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #(5_000_000);
    $display("three_address_register_machine_exec_top: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tarm_pkg.sv
rtl/core/tarm_ctrl.sv
rtl/core/tarm_datapath.sv
rtl/core/three_address_register_machine_exec_top.sv
rtl/core/tarm_checker.sv
tb/testbench.sv
